FILE: hdl/ilp_pkg.sv
`default_nettype none
package ilp_pkg;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int CHAN_W   = 2;
	localparam int COEF_W   = 9;
	localparam int OFF_W    = 7;
	localparam int LIGHT_W  = 7;
	localparam int ACC_W    = 25;
	localparam int FRAC_W   = 8;
	localparam int OUT_DATA_W = 24;

	// serial gain multiply: gain consumed one 3-bit digit per cycle
	localparam int DIGIT_W  = 3;
	localparam int DIGITS   = (COEF_W + DIGIT_W - 1) / DIGIT_W;
	localparam int DIFF_W   = ACC_W + 1 - FRAC_W;
	localparam int MCAND_W  = DIFF_W + DIGIT_W * (DIGITS - 1);
	localparam int SUM_W    = ACC_W + 3;

	// light scaling
	localparam int LIGHT_SHIFT = 10;
	localparam logic [LIGHT_W-1:0] LIGHT_MAX = 7'd100;

	// register reset values
	localparam logic [COEF_W-1:0] COEF_CH0_RST = 9'd160;
	localparam logic [COEF_W-1:0] COEF_CH1_RST = 9'd160;
	localparam logic [COEF_W-1:0] COEF_CH2_RST = 9'd4;
	localparam logic [OFF_W-1:0]  OFFSET_RST   = 7'd20;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_COEF_CH0,
		REG_COEF_CH1,
		REG_COEF_CH2,
		REG_LIGHT_OFFSET
	} reg_idx_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: hdl/ilp_mac.sv
`default_nettype none
// Digit-serial multiply-accumulate: acc + d * coef, one gain digit per cycle,
// saturated to the accumulator range.
module ilp_mac (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [ilp_pkg::DIFF_W-1:0] d,
	input  wire logic        [ilp_pkg::COEF_W-1:0] coef,
	input  wire logic signed [ilp_pkg::ACC_W-1:0]  acc_in,
	output logic                                   done,
	output logic signed      [ilp_pkg::ACC_W-1:0]  acc_out
);

	localparam int CNT_W = $clog2(ilp_pkg::DIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ilp_pkg::DIGITS - 1);

	logic                                busy_q;
	logic                                done_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic signed [ilp_pkg::SUM_W-1:0]    sum_q;
	logic signed [ilp_pkg::MCAND_W-1:0]  mcand_q;
	logic [ilp_pkg::COEF_W-1:0]          coef_q;
	logic signed [ilp_pkg::SUM_W-1:0]    pp;
	logic signed [ilp_pkg::SUM_W-1:0]    digit_ext;

	// partial product of the shifted multiplicand and the low gain digit
	always_comb begin
		digit_ext = $signed({{(ilp_pkg::SUM_W - ilp_pkg::DIGIT_W){1'b0}},
			coef_q[ilp_pkg::DIGIT_W-1:0]});
		pp = ilp_pkg::SUM_W'(mcand_q) * digit_ext;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: sum grows by one digit product, multiplicand moves up a digit
	always_ff @(posedge clk) begin
		if (start) begin
			sum_q   <= ilp_pkg::SUM_W'(acc_in);
			mcand_q <= ilp_pkg::MCAND_W'(d);
			coef_q  <= coef;
		end else if (busy_q) begin
			sum_q   <= sum_q + pp;
			mcand_q <= mcand_q <<< ilp_pkg::DIGIT_W;
			coef_q  <= coef_q >> ilp_pkg::DIGIT_W;
		end
	end

	// saturate to the accumulator range
	always_comb begin
		if (sum_q[ilp_pkg::SUM_W-1:ilp_pkg::ACC_W-1] == '0 ||
			sum_q[ilp_pkg::SUM_W-1:ilp_pkg::ACC_W-1] == '1) begin
			acc_out = sum_q[ilp_pkg::ACC_W-1:0];
		end else if (sum_q[ilp_pkg::SUM_W-1]) begin
			acc_out = {1'b1, {(ilp_pkg::ACC_W-1){1'b0}}};
		end else begin
			acc_out = {1'b0, {(ilp_pkg::ACC_W-1){1'b1}}};
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

FILE: hdl/ilp_light.sv
`default_nettype none
// Light level: max(v,0)*100 >> 10, minus offset, clamped to 0..100.
module ilp_light (
	input  wire logic signed [ilp_pkg::SAMPLE_W-1:0] filtered,
	input  wire logic        [ilp_pkg::OFF_W-1:0]    offset,
	output logic             [ilp_pkg::LIGHT_W-1:0]  level
);

	localparam int V_W = ilp_pkg::SAMPLE_W - 1;
	localparam int P_W = V_W + 7;
	localparam int Q_W = P_W - ilp_pkg::LIGHT_SHIFT;

	logic [V_W-1:0]   v;
	logic [P_W-1:0]   p;
	logic [Q_W-1:0]   q;
	logic signed [Q_W:0] lvl;

	always_comb begin
		v   = filtered[ilp_pkg::SAMPLE_W-1] ? '0 : filtered[V_W-1:0];
		// times 100 as 64 + 32 + 4
		p   = (P_W'(v) << 6) + (P_W'(v) << 5) + (P_W'(v) << 2);
		q   = p[P_W-1:ilp_pkg::LIGHT_SHIFT];
		lvl = $signed({1'b0, q}) - $signed((Q_W + 1)'(offset));
		if (lvl[Q_W]) begin
			level = '0;
		end else if (lvl > $signed((Q_W + 1)'(ilp_pkg::LIGHT_MAX))) begin
			level = ilp_pkg::LIGHT_MAX;
		end else begin
			level = lvl[ilp_pkg::LIGHT_W-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/multichannel_iir_lowpass_light_level.sv
`default_nettype none
// Channel  | Dir | Bus                          | Contents
// s        | in  | s_tvalid/s_tready/s_tdata/tuser | sample in tdata, channel in tuser
// m        | out | m_tvalid/m_tready/m_tdata/tuser | filtered, light_percent; channel
// cfg      | in  | cfg_valid/cfg_ready/index/data  | gains and light offset
//
// A primed channel's sample goes through accept, serial gain multiply (3 gain
// bits per cycle), accumulator write-back and output fill.
// A first sample or an invalid channel goes from accept straight to output fill.
// Reset clears the primed flags and loads the register defaults.
// A new sample is taken while the previous result waits in the output register;
// a stalled output holds the sequencer in its final state.
module multichannel_iir_lowpass_light_level #(
	parameter int CHANNELS = 3
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// sample stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [ilp_pkg::SAMPLE_W-1:0]    s_tdata,  // [15:0] sample
	input  wire logic [ilp_pkg::CHAN_W-1:0]      s_tuser,  // [1:0] channel
	// result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [ilp_pkg::OUT_DATA_W-1:0]       m_tdata,  // [15:0] filtered, [22:16] light_percent
	output logic [ilp_pkg::CHAN_W-1:0]           m_tuser,  // [1:0] out_channel
	// configuration writes
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [ilp_pkg::COEF_W-1:0]      cfg_data
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SAMP_W = ilp_pkg::SAMPLE_W;
	localparam int ACC_W  = ilp_pkg::ACC_W;
	localparam int F_W    = ACC_W - ilp_pkg::FRAC_W + 1;

	ilp_pkg::state_t state_q, state_d;

	logic [ilp_pkg::COEF_W-1:0] coef0_q, coef1_q, coef2_q;
	logic [ilp_pkg::OFF_W-1:0]  offset_q;

	logic signed [ACC_W-1:0] acc_q [CHANNELS];
	logic [CHANNELS-1:0]     primed_q;

	logic [ilp_pkg::CHAN_W-1:0] ch_q;
	logic signed [SAMP_W-1:0]   f_q;

	logic                       m_tvalid_q;
	logic [ilp_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [ilp_pkg::CHAN_W-1:0] m_tuser_q;

	logic                       s_acc;
	logic                       valid_ch;
	logic                       ch_primed;
	logic [CH_W-1:0]            in_idx;
	logic [CH_W-1:0]            cur_idx;
	logic signed [SAMP_W-1:0]   sample;
	logic [ilp_pkg::COEF_W-1:0] coef_sel;
	logic signed [ACC_W:0]      diff;
	logic signed [ilp_pkg::DIFF_W-1:0] d;
	logic                       mac_start;
	logic                       mac_done;
	logic signed [ACC_W-1:0]    mac_acc;
	logic signed [F_W:0]        f_round;
	logic signed [SAMP_W-1:0]   f_sat;
	logic [ilp_pkg::LIGHT_W-1:0] light;
	logic                       load_out;

	assign sample    = $signed(s_tdata);
	assign in_idx    = s_tuser[CH_W-1:0];
	assign cur_idx   = ch_q[CH_W-1:0];
	assign valid_ch  = (s_tuser < ilp_pkg::CHAN_W'(CHANNELS));
	assign ch_primed = valid_ch && primed_q[in_idx];
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef0_q  <= ilp_pkg::COEF_CH0_RST;
			coef1_q  <= ilp_pkg::COEF_CH1_RST;
			coef2_q  <= ilp_pkg::COEF_CH2_RST;
			offset_q <= ilp_pkg::OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ilp_pkg::reg_idx_t'(cfg_index))
				ilp_pkg::REG_COEF_CH0:     coef0_q  <= cfg_data;
				ilp_pkg::REG_COEF_CH1:     coef1_q  <= cfg_data;
				ilp_pkg::REG_COEF_CH2:     coef2_q  <= cfg_data;
				ilp_pkg::REG_LIGHT_OFFSET: offset_q <= cfg_data[ilp_pkg::OFF_W-1:0];
			endcase
		end
	end

	// gain of the incoming channel
	always_comb begin
		case (s_tuser)
			2'd1:    coef_sel = coef1_q;
			2'd2:    coef_sel = coef2_q;
			default: coef_sel = coef0_q;
		endcase
	end

	// (sample*256 - acc) >>> 8
	always_comb begin
		diff = $signed({{1{sample[SAMP_W-1]}}, sample, {ilp_pkg::FRAC_W{1'b0}}})
			- $signed({acc_q[in_idx][ACC_W-1], acc_q[in_idx]});
		d = diff[ACC_W:ilp_pkg::FRAC_W];
	end

	ilp_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mac_start),
		.d       (d),
		.coef    (coef_sel),
		.acc_in  (acc_q[in_idx]),
		.done    (mac_done),
		.acc_out (mac_acc)
	);

	// rounded, saturated output of the new accumulator
	always_comb begin
		f_round = $signed({mac_acc[ACC_W-1], mac_acc[ACC_W-1:ilp_pkg::FRAC_W]})
			+ $signed({{F_W{1'b0}}, mac_acc[ilp_pkg::FRAC_W-1]});
		if (f_round[F_W:SAMP_W-1] == '0 || f_round[F_W:SAMP_W-1] == '1) begin
			f_sat = f_round[SAMP_W-1:0];
		end else if (f_round[F_W]) begin
			f_sat = {1'b1, {(SAMP_W-1){1'b0}}};
		end else begin
			f_sat = {1'b0, {(SAMP_W-1){1'b1}}};
		end
	end

	ilp_light u_light (
		.filtered (f_q),
		.offset   (offset_q),
		.level    (light)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mac_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ilp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (ch_primed) begin
						mac_start = 1'b1;
						state_d   = ilp_pkg::ST_MAC;
					end else begin
						state_d = ilp_pkg::ST_DONE;
					end
				end
			end
			ilp_pkg::ST_MAC: begin
				if (mac_done) begin
					state_d = ilp_pkg::ST_DONE;
				end
			end
			ilp_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ilp_pkg::ST_IDLE;
				end
			end
			default: state_d = ilp_pkg::ST_IDLE;
		endcase
	end

	// primed flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= '0;
		end else if (s_acc && valid_ch) begin
			primed_q[in_idx] <= 1'b1;
		end
	end

	// accumulators and current request
	always_ff @(posedge clk) begin
		if (s_acc) begin
			ch_q <= s_tuser;
			if (!valid_ch) begin
				f_q <= '0;
			end else if (!primed_q[in_idx]) begin
				f_q            <= sample;
				acc_q[in_idx]  <= $signed({sample[SAMP_W-1],
					sample, {ilp_pkg::FRAC_W{1'b0}}});
			end
		end else if (mac_done) begin
			acc_q[cur_idx] <= mac_acc;
			f_q            <= f_sat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {1'b0, light, f_q};
			m_tuser_q <= ch_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ilp_pkg::ST_MAC)
		else $error("multiply finished outside its state");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> state_q != ilp_pkg::ST_IDLE)
		else $error("accepted sample did not start work");

	a_light_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[22:16] <= ilp_pkg::LIGHT_MAX)
		else $error("light level above 100");

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_tvalid && state_q == ilp_pkg::ST_IDLE)
		else $error("result load did not reach the output");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
	import ilp_pkg::*;

	localparam int NUM_CH      = 3;
	localparam int STALL_LIMIT = 3000;  // cycles without any sample, result or config handshake
	localparam int HOLD_CYCLES = 400;   // long result-side hold-off

	typedef struct {
		logic [CHAN_W-1:0]          channel;
		logic signed [SAMPLE_W-1:0] sample;
	} sample_req_t;

	typedef struct {
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] filtered;
		logic [LIGHT_W-1:0]  light;
	} filter_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [SAMPLE_W-1:0]      s_tdata = '0;   // [15:0] sample
	logic [CHAN_W-1:0]        s_tuser = '0;   // [1:0] channel
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]    m_tdata;        // [15:0] filtered, [22:16] light_percent
	logic [CHAN_W-1:0]        m_tuser;        // [1:0] out_channel
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [1:0]               cfg_index = '0;
	logic [COEF_W-1:0]        cfg_data = '0;

	multichannel_iir_lowpass_light_level dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock, 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the block's registers and per-channel filter state
	logic [COEF_W-1:0] gain [NUM_CH];
	logic [OFF_W-1:0]  light_off;
	longint            acc_shadow [NUM_CH];
	bit                primed_shadow [NUM_CH];

	sample_req_t    pending_samples [$];
	filter_result_t expected_results [$];
	int             mismatches = 0;

	// expected result of one accepted sample; updates the shadow state
	function automatic filter_result_t filter_sample(sample_req_t req);
		filter_result_t r;
		longint s, acc, step, f, v, lvl;
		int ch;
		r.channel = req.channel;
		r.filtered = '0;
		r.light = '0;
		if (req.channel >= NUM_CH)
			return r;
		ch = req.channel;
		s = req.sample;
		if (!primed_shadow[ch]) begin
			acc_shadow[ch] = s * 256;
			primed_shadow[ch] = 1'b1;
			f = s;
		end else begin
			acc = acc_shadow[ch];
			step = (s * 256 - acc) >>> FRAC_W;
			acc = acc + step * longint'(gain[ch]);
			if (acc > 64'sd16777215) acc = 64'sd16777215;
			if (acc < -64'sd16777216) acc = -64'sd16777216;
			acc_shadow[ch] = acc;
			f = (acc >>> FRAC_W) + longint'(acc[7]);
			if (f > 32767) f = 32767;
			if (f < -32768) f = -32768;
		end
		r.filtered = f[SAMPLE_W-1:0];
		v = (f < 0) ? 0 : f;
		lvl = (v * 100) / 1024 - longint'(light_off);
		if (lvl < 0) lvl = 0;
		if (lvl > 100) lvl = 100;
		r.light = lvl[LIGHT_W-1:0];
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic sample_req_t rand_sample();
		sample_req_t req;
		int pick;
		pick = $urandom_range(0, 9);
		req.channel = (pick == 0) ? 2'd3 : CHAN_W'($urandom_range(0, NUM_CH - 1));
		pick = $urandom_range(0, 9);
		if (pick < 4)
			req.sample = SAMPLE_W'($urandom);
		else if (pick < 8)
			req.sample = SAMPLE_W'($urandom_range(0, 1500));
		else if (pick == 8)
			req.sample = SAMPLE_W'($urandom_range(32760, 32767));
		else
			req.sample = SAMPLE_W'(16'h8000 | $urandom_range(0, 7));
		return req;
	endfunction

	// sample driver
	int send_gap = 0;
	int send_calm = 0;
	always @(posedge clk or negedge arst_n) begin
		logic nxt_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(filter_sample(pending_samples.pop_front()));
				if (send_calm > 0) begin
					send_calm--;
				end else begin
					send_gap = gap_len();
					if ($urandom_range(0, 63) == 0)
						send_calm = $urandom_range(20, 60);
				end
			end
			nxt_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_samples.size() > 0) begin
				nxt_valid = 1'b1;
				s_tdata <= pending_samples[0].sample;
				s_tuser <= pending_samples[0].channel;
			end
			s_tvalid <= nxt_valid;
		end
	end

	// result monitor and checker
	int recv_stall = 0;
	int recv_calm = 0;
	int recv_hold = 0;
	int results_seen = 0;
	always @(posedge clk or negedge arst_n) begin
		filter_result_t want;
		logic nxt_ready;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, actual ch %0d filtered %0d light %0d",
						$time, m_tuser, $signed(m_tdata[15:0]), m_tdata[22:16]);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.channel) begin
						$display("%0t: out_channel expected %0d actual %0d",
							$time, want.channel, m_tuser);
						mismatches++;
					end
					if (m_tdata[15:0] !== want.filtered) begin
						$display("%0t: filtered (ch %0d) expected %0d actual %0d", $time,
							want.channel, $signed(want.filtered), $signed(m_tdata[15:0]));
						mismatches++;
					end
					if (m_tdata[22:16] !== want.light) begin
						$display("%0t: light_percent (ch %0d) expected %0d actual %0d",
							$time, want.channel, want.light, m_tdata[22:16]);
						mismatches++;
					end
				end
				// long hold-off so the block backs up into its input
				if (results_seen == 120 || results_seen == 520)
					recv_hold = HOLD_CYCLES;
				else if (recv_calm > 0)
					recv_calm--;
				else begin
					recv_stall = gap_len();
					if ($urandom_range(0, 63) == 0)
						recv_calm = $urandom_range(20, 60);
				end
			end else if (recv_calm == 0 && recv_stall == 0 && recv_hold == 0 &&
					$urandom_range(0, 15) == 0) begin
				recv_stall = gap_len();
			end
			nxt_ready = 1'b0;
			if (recv_hold > 0)
				recv_hold--;
			else if (recv_stall > 0)
				recv_stall--;
			else
				nxt_ready = 1'b1;
			m_tready <= nxt_ready;
		end
	end

	// watchdog: ends a run where nothing moves for too long
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [COEF_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_COEF_CH0: gain[0] = val;
			REG_COEF_CH1: gain[1] = val;
			REG_COEF_CH2: gain[2] = val;
			REG_LIGHT_OFFSET: light_off = val[OFF_W-1:0];
		endcase
	endtask

	task automatic set_regs(logic [COEF_W-1:0] g0, logic [COEF_W-1:0] g1,
			logic [COEF_W-1:0] g2, logic [COEF_W-1:0] off);
		write_reg(REG_COEF_CH0, g0);
		write_reg(REG_COEF_CH1, g1);
		write_reg(REG_COEF_CH2, g2);
		write_reg(REG_LIGHT_OFFSET, off);
	endtask

	task automatic push_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
		sample_req_t req;
		req.channel = ch;
		req.sample = smp;
		@(negedge clk);
		pending_samples.push_back(req);
	endtask

	// hold the sender until every outstanding result has come back
	task automatic wait_drained();
		@(negedge clk);
		while (pending_samples.size() > 0 || expected_results.size() > 0)
			@(negedge clk);
	endtask

	initial begin
		gain[0] = COEF_CH0_RST;
		gain[1] = COEF_CH1_RST;
		gain[2] = COEF_CH2_RST;
		light_off = OFFSET_RST;
		for (int i = 0; i < NUM_CH; i++) begin
			acc_shadow[i] = 0;
			primed_shadow[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: invalid channel, first samples pass straight through
		push_sample(2'd3, 16'd1234);
		push_sample(2'd0, 16'h8000);
		push_sample(2'd1, 16'h7fff);
		push_sample(2'd2, 16'h0000);
		push_sample(2'd3, 16'hffff);
		push_sample(2'd0, 16'h7fff);
		push_sample(2'd0, 16'h7fff);
		push_sample(2'd1, 16'h0000);
		push_sample(2'd1, 16'hffff);
		push_sample(2'd2, 16'd1000);
		push_sample(2'd2, 16'd1000);
		push_sample(2'd0, 16'd300);
		wait_drained();

		// oversized gains drive the accumulator and output into saturation
		set_regs(9'd511, 9'd256, 9'd0, 9'd100);
		push_sample(2'd0, 16'h7fff);
		push_sample(2'd0, 16'h8000);
		push_sample(2'd0, 16'h7fff);
		push_sample(2'd0, 16'h8000);
		push_sample(2'd1, 16'h5555);
		push_sample(2'd1, 16'haaaa);
		push_sample(2'd2, 16'd12345);
		push_sample(2'd1, 16'd1200);
		wait_drained();

		// random phases, each under its own register setting
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_regs(COEF_W'($urandom_range(0, 256)), COEF_W'($urandom_range(0, 256)),
					COEF_W'($urandom_range(0, 256)), COEF_W'($urandom_range(0, 100)));
				1: set_regs(9'd0, 9'd256, 9'd511, 9'h1ff);
				2: set_regs(9'd1, 9'd255, 9'd128, 9'd0);
				default: set_regs(COEF_CH0_RST, COEF_CH1_RST, COEF_CH2_RST, 9'(OFFSET_RST));
			endcase
			@(negedge clk);
			for (int n = 0; n < 225; n++)
				pending_samples.push_back(rand_sample());
			wait_drained();
		end

		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

FILE: files.f
hdl/ilp_pkg.sv
hdl/ilp_mac.sv
hdl/ilp_light.sv
hdl/multichannel_iir_lowpass_light_level.sv
tb/sv/tb.sv
